@@ rtl/bbpc_pkg.sv @@
package bbpc_pkg;

    localparam int COORD_W  = 32;
    localparam int REG_W    = 64;
    localparam int REG_NUM  = 8;
    localparam int IDX_W    = 4;
    localparam int PROD_W   = 48;
    localparam int SUM_W    = 50;
    localparam int REM_W    = 51;
    localparam int Q_W      = 31;
    localparam int NLO_W    = 15;
    localparam int XF_LAT   = 2;
    localparam int DIV_LAT  = Q_W + 2;
    localparam int PIPE_LAT = XF_LAT + DIV_LAT;
    localparam int CORNERS  = 8;
    localparam int K_W      = 3;

    localparam logic signed [COORD_W-1:0] FIX_ONE = 32'sh0001_0000;
    localparam logic signed [COORD_W-1:0] SAT_POS = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] SAT_NEG = 32'sh8000_0000;

    localparam logic [REG_W-1:0] MAT_RST [REG_NUM] = '{
        64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
        64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
    };

    typedef logic [REG_W-1:0] mat_t [REG_NUM];

    typedef struct packed {
        logic signed [COORD_W-1:0] box_low_x;
        logic signed [COORD_W-1:0] box_low_y;
        logic signed [COORD_W-1:0] box_low_z;
        logic signed [COORD_W-1:0] box_high_x;
        logic signed [COORD_W-1:0] box_high_y;
        logic signed [COORD_W-1:0] box_high_z;
    } in_t;

    typedef struct packed {
        logic                      visible;
        logic                      behind_viewer;
        logic signed [COORD_W-1:0] rect_min_x;
        logic signed [COORD_W-1:0] rect_min_y;
        logic signed [COORD_W-1:0] rect_max_x;
        logic signed [COORD_W-1:0] rect_max_y;
        logic signed [COORD_W-1:0] max_depth;
    } out_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } tag_t;

endpackage

@@ rtl/bbpc_xform.sv @@
module bbpc_xform
    import bbpc_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  mat_t                      mat,
    input  logic signed [COORD_W-1:0] vx,
    input  logic signed [COORD_W-1:0] vy,
    input  logic signed [COORD_W-1:0] vz,
    output logic signed [SUM_W-1:0]   sum [4]
);

    logic signed [PROD_W-1:0]  prod_reg  [4][3];
    logic signed [PROD_W-1:0]  prod_next [4][3];
    logic signed [SUM_W-1:0]   sum_reg   [4];
    logic signed [COORD_W-1:0] vec [3];

    assign vec[0] = vx;
    assign vec[1] = vy;
    assign vec[2] = vz;

    function automatic logic signed [COORD_W-1:0] entry(input mat_t m, input int r, input int c);
        logic [REG_W-1:0] rg;
        rg = m[2*r + c/2];
        return (c % 2 == 1) ? $signed(rg[63:32]) : $signed(rg[31:0]);
    endfunction

    // floor to s.16 is the upper bits of the exact product
    always_comb
    begin
        logic signed [2*COORD_W-1:0] p;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                p = entry(mat, r, c) * vec[c];
                prod_next[r][c] = p[2*COORD_W-1:16];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r][c] <= prod_next[r][c];
                end
                sum_reg[r] <= SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1])
                            + SUM_W'(prod_reg[r][2]) + SUM_W'(entry(mat, r, 3));
            end
        end
    end

    assign sum = sum_reg;

endmodule

@@ rtl/bbpc_div.sv @@
module bbpc_div
    import bbpc_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [SUM_W-1:0]   num,
    input  logic signed [SUM_W-1:0]   den,
    output logic signed [COORD_W-1:0] quot
);

    logic [REM_W-1:0]   rem_reg  [Q_W+1];
    logic [Q_W-1:0]     q_reg    [Q_W+1];
    logic [NLO_W-1:0]   nlo_reg  [Q_W+1];
    logic [SUM_W-1:0]   d_reg    [Q_W+1];
    logic               spec_reg [Q_W+1];
    logic               neg_reg  [Q_W+1];
    logic [COORD_W-1:0] sval_reg [Q_W+1];
    logic [COORD_W-1:0] quot_reg;

    logic [SUM_W-1:0]   n_abs;
    logic [SUM_W-1:0]   d_abs;
    logic               ovf;
    logic               dz;
    logic               spec_next;
    logic [COORD_W-1:0] sval_next;

    assign n_abs = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
    assign d_abs = den[SUM_W-1] ? SUM_W'(-den) : SUM_W'(den);
    assign dz    = (den == '0);
    assign ovf   = {15'd0, n_abs} >= {d_abs, 15'd0};

    always_comb
    begin
        spec_next = dz ? (num != '0) : ovf;
        if (dz)
            sval_next = num[SUM_W-1] ? SAT_NEG : SAT_POS;
        else
            sval_next = (num[SUM_W-1] ^ den[SUM_W-1]) ? SAT_NEG : SAT_POS;
        if (dz && num == '0)
        begin
            spec_next = 1'b1;
            sval_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= REM_W'(n_abs >> NLO_W);
            q_reg[0]    <= '0;
            nlo_reg[0]  <= n_abs[NLO_W-1:0];
            d_reg[0]    <= d_abs;
            spec_reg[0] <= spec_next;
            neg_reg[0]  <= num[SUM_W-1] ^ den[SUM_W-1];
            sval_reg[0] <= sval_next;
        end
    end

    // one quotient bit per stage, restoring
    for (genvar j = 0; j < Q_W; j++)
    begin : g_step
        logic [REM_W-1:0] t;
        logic             take;
        assign t    = {rem_reg[j][REM_W-2:0], nlo_reg[j][NLO_W-1]};
        assign take = t >= {1'b0, d_reg[j]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1]  <= take ? (t - {1'b0, d_reg[j]}) : t;
                q_reg[j+1]    <= {q_reg[j][Q_W-2:0], take};
                nlo_reg[j+1]  <= {nlo_reg[j][NLO_W-2:0], 1'b0};
                d_reg[j+1]    <= d_reg[j];
                spec_reg[j+1] <= spec_reg[j];
                neg_reg[j+1]  <= neg_reg[j];
                sval_reg[j+1] <= sval_reg[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (spec_reg[Q_W])
                quot_reg <= sval_reg[Q_W];
            else if (neg_reg[Q_W])
                quot_reg <= -{1'b0, q_reg[Q_W]};
            else
                quot_reg <= {1'b0, q_reg[Q_W]};
        end
    end

    assign quot = $signed(quot_reg);

endmodule

@@ rtl/bbpc_reduce.sv @@
module bbpc_reduce
    import bbpc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  tag_t                      tag,
    input  logic signed [COORD_W-1:0] px,
    input  logic signed [COORD_W-1:0] py,
    input  logic signed [COORD_W-1:0] pz,
    output logic                      res_valid,
    output out_t                      res
);

    logic signed [COORD_W-1:0] mnx_reg, mny_reg, mxx_reg, mxy_reg, mz_reg;
    logic signed [COORD_W-1:0] mnx_next, mny_next, mxx_next, mxy_next, mz_next;
    logic                      valid_reg;
    out_t                      res_reg;
    logic                      behind;

    function automatic logic inside_unit(input logic signed [COORD_W-1:0] v);
        return (v > -FIX_ONE) && (v < FIX_ONE);
    endfunction

    always_comb
    begin
        logic signed [COORD_W-1:0] bnx, bny, bxx, bxy, bz;
        bnx = tag.first ? SAT_POS : mnx_reg;
        bny = tag.first ? SAT_POS : mny_reg;
        bxx = tag.first ? SAT_NEG : mxx_reg;
        bxy = tag.first ? SAT_NEG : mxy_reg;
        bz  = tag.first ? -FIX_ONE : mz_reg;
        mnx_next = (px < bnx) ? px : bnx;
        mxx_next = (px > bxx) ? px : bxx;
        mny_next = (py < bny) ? py : bny;
        mxy_next = (py > bxy) ? py : bxy;
        mz_next  = (pz > bz) ? pz : bz;
    end

    assign behind = mz_next < 0;

    always_ff @(posedge clk)
    begin
        if (en && tag.valid)
        begin
            mnx_reg <= mnx_next;
            mny_reg <= mny_next;
            mxx_reg <= mxx_next;
            mxy_reg <= mxy_next;
            mz_reg  <= mz_next;
            if (tag.last)
            begin
                res_reg.visible       <= !behind
                    && (inside_unit(mnx_next) || inside_unit(mxx_next))
                    && (inside_unit(mny_next) || inside_unit(mxy_next));
                res_reg.behind_viewer <= behind;
                res_reg.rect_min_x    <= mnx_next;
                res_reg.rect_min_y    <= mny_next;
                res_reg.rect_max_x    <= mxx_next;
                res_reg.rect_max_y    <= mxy_next;
                res_reg.max_depth     <= mz_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= tag.valid && tag.last;
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

@@ rtl/bounding_box_projection_cull.sv @@
// A corner passes the transform's product and sum registers, the divider's input, step
// and quotient registers, and the result register. Corners issue one per cycle, unless
// the output stalls, into a shared transform and divide pipeline; the next box is taken
// as its last corner issues. Reset: rst_n clears control and valid state
// asynchronously and loads the identity matrix into the configuration registers.
module bounding_box_projection_cull
    import bbpc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_index,
    input  logic [REG_W-1:0] wr_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_t              in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_t             out_data
);

    // Matrix registers, two s16.16 entries each; indexes past the list drop.
    mat_t mat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_NUM; i++)
                mat_reg[i] <= MAT_RST[i];
        end
        else if (wr_en && (wr_index < IDX_W'(REG_NUM)))
        begin
            mat_reg[wr_index[K_W-1:0]] <= wr_data;
        end
    end

    // Global advance: the whole pipeline holds only while a finished result
    // waits at the output and the receiver stalls.
    logic en;
    assign en = !(out_valid && out_stall);

    // Corner sequencer: hold the box, step through the eight corners.
    in_t            box_reg;
    logic           busy_reg;
    logic [K_W-1:0] k_reg;
    logic           last_corner;
    logic           accept;

    assign last_corner = (k_reg == K_W'(CORNERS - 1));
    assign in_stall    = busy_reg && !(last_corner && en);
    assign accept      = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else if (accept)
        begin
            busy_reg <= 1'b1;
            k_reg    <= '0;
        end
        else if (busy_reg && en)
        begin
            k_reg <= k_reg + 1'b1;
            if (last_corner)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            box_reg <= in_data;
    end

    // Corner k takes high x when bit 2 is set, high y on bit 1, high z on bit 0.
    logic signed [COORD_W-1:0] cx, cy, cz;
    assign cx = k_reg[2] ? box_reg.box_high_x : box_reg.box_low_x;
    assign cy = k_reg[1] ? box_reg.box_high_y : box_reg.box_low_y;
    assign cz = k_reg[0] ? box_reg.box_high_z : box_reg.box_low_z;

    // Tag pipe: marks valid, first and last corner alongside the data path.
    tag_t tag_in;
    tag_t tag_reg [PIPE_LAT];

    assign tag_in.valid = busy_reg;
    assign tag_in.first = (k_reg == '0);
    assign tag_in.last  = last_corner;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_LAT; i++)
                tag_reg[i] <= '0;
        end
        else if (en)
        begin
            tag_reg[0] <= tag_in;
            for (int i = 1; i < PIPE_LAT; i++)
                tag_reg[i] <= tag_reg[i-1];
        end
    end

    // Matrix-vector product: multiply stage then row-sum stage.
    logic signed [SUM_W-1:0] sum [4];

    bbpc_xform u_xform
    (
        .clk (clk),
        .en  (en),
        .mat (mat_reg),
        .vx  (cx),
        .vy  (cy),
        .vz  (cz),
        .sum (sum)
    );

    // Perspective divide: three lanes sharing the w row as divisor.
    logic signed [COORD_W-1:0] px, py, pz;

    bbpc_div u_div_x
    (
        .clk  (clk),
        .en   (en),
        .num  (sum[0]),
        .den  (sum[3]),
        .quot (px)
    );

    bbpc_div u_div_y
    (
        .clk  (clk),
        .en   (en),
        .num  (sum[1]),
        .den  (sum[3]),
        .quot (py)
    );

    bbpc_div u_div_z
    (
        .clk  (clk),
        .en   (en),
        .num  (sum[2]),
        .den  (sum[3]),
        .quot (pz)
    );

    // Rectangle and depth tracking; output register parts the two sides.
    bbpc_reduce u_reduce
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .tag       (tag_reg[PIPE_LAT-1]),
        .px        (px),
        .py        (py),
        .pz        (pz),
        .res_valid (out_valid),
        .res       (out_data)
    );

    a_cull_consistent : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.visible && out_data.behind_viewer))
        else $error("visible box also flagged behind viewer");

    a_depth_floor : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.max_depth >= -FIX_ONE))
        else $error("max depth below -1.0");

    a_rect_order : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.rect_min_x <= out_data.rect_max_x)
                   && (out_data.rect_min_y <= out_data.rect_max_y))
        else $error("rectangle minimum above maximum");

    a_seq_accept : assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !last_corner) |-> in_stall)
        else $error("box taken while corners still issuing");

endmodule

@@ sim/tb_bounding_box_projection_cull.sv @@
module tb_bounding_box_projection_cull;
    import bbpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Stimulus sizes, settle time and the number of mismatches to report in full.
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_BOXES   = 222;
    localparam int SETTLE_CYCLES = PIPE_LAT + 24;
    localparam int REPORT_LIMIT  = 10;

    // Register indexes, in the order of the register map.
    typedef enum logic [IDX_W-1:0] {
        R0_C01 = 4'd0, R0_C23 = 4'd1, R1_C01 = 4'd2, R1_C23 = 4'd3,
        R2_C01 = 4'd4, R2_C23 = 4'd5, R3_C01 = 4'd6, R3_C23 = 4'd7,
        IDX_UNUSED = 4'd11
    } mat_idx_e;

    // Fixed-point constants used to build the matrices.
    localparam int Q_ONE     = 32'sh0001_0000;
    localparam int Q_NEG_ONE = -32'sh0001_0000;
    localparam int Q_TWO     = 32'sh0002_0000;
    localparam int Q_MAX     = 32'sh7FFF_FFFF;
    localparam int Q_MIN     = 32'sh8000_0000;

    logic             clk;
    logic             rst_n;
    logic             wr_en;
    logic [IDX_W-1:0] wr_index;
    logic [REG_W-1:0] wr_data;
    logic             in_valid;
    logic             in_stall;
    in_t              in_data;
    logic             out_valid;
    logic             out_stall;
    out_t             out_data;

    bounding_box_projection_cull dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Shadow of the matrix registers, and the rectangles still owed by the block.
    logic [REG_W-1:0] matrix_copy [REG_NUM];
    out_t             pending_rects [$];
    int               mismatch_count;
    int               burst_left;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic longint mat_entry(int r, int c);
        logic [REG_W-1:0] reg_word;
        logic [31:0]      half;
        reg_word = matrix_copy[2 * r + c / 2];
        half     = (c % 2 == 1) ? reg_word[63:32] : reg_word[31:0];
        return longint'($signed(half));
    endfunction

    // Each product is exact, then floored to s.16; the floored terms sum exactly.
    function automatic longint row_product(int r, longint vec [4]);
        longint acc;
        acc = 0;
        for (int c = 0; c < 4; c++)
            acc += (mat_entry(r, c) * vec[c]) >>> 16;
        return acc;
    endfunction

    // Truncating s16.16 divide that saturates on overflow and on a zero divisor with a nonzero numerator.
    function automatic longint q16_divide(longint num, longint den);
        logic        neg;
        bit   [63:0] n_mag;
        bit   [63:0] d_mag;
        bit   [63:0] whole;
        bit   [63:0] rem;
        bit   [63:0] frac;
        longint      mag;
        if (den == 0)
            return (num > 0) ? longint'(Q_MAX) : (num < 0) ? longint'(Q_MIN) : 0;
        neg   = (num < 0) != (den < 0);
        n_mag = (num < 0) ? -num : num;
        d_mag = (den < 0) ? -den : den;
        whole = n_mag / d_mag;
        rem   = n_mag % d_mag;
        if (whole >= 32768)
            return neg ? longint'(Q_MIN) : longint'(Q_MAX);
        frac = 0;
        for (int i = 0; i < 16; i++)
        begin
            rem  = rem << 1;
            frac = frac << 1;
            if (rem >= d_mag)
            begin
                rem  = rem - d_mag;
                frac = frac | 1;
            end
        end
        mag = longint'((whole << 16) | frac);
        return neg ? -mag : mag;
    endfunction

    function automatic logic in_unit(longint v);
        return (v > -longint'(Q_ONE)) && (v < longint'(Q_ONE));
    endfunction

    // Project all eight corners and reduce to the screen rectangle and the depth.
    function automatic out_t project_box(in_t b);
        longint vec [4];
        longint w_sum;
        longint px;
        longint py;
        longint pz;
        longint min_x;
        longint min_y;
        longint max_x;
        longint max_y;
        longint depth;
        out_t   res;
        min_x = Q_MAX;
        min_y = Q_MAX;
        max_x = Q_MIN;
        max_y = Q_MIN;
        depth = Q_NEG_ONE;
        for (int k = 0; k < CORNERS; k++)
        begin
            vec[0] = (k & 4) ? longint'(b.box_high_x) : longint'(b.box_low_x);
            vec[1] = (k & 2) ? longint'(b.box_high_y) : longint'(b.box_low_y);
            vec[2] = (k & 1) ? longint'(b.box_high_z) : longint'(b.box_low_z);
            vec[3] = Q_ONE;
            w_sum  = row_product(3, vec);
            px     = q16_divide(row_product(0, vec), w_sum);
            py     = q16_divide(row_product(1, vec), w_sum);
            pz     = q16_divide(row_product(2, vec), w_sum);
            if (px < min_x) min_x = px;
            if (px > max_x) max_x = px;
            if (py < min_y) min_y = py;
            if (py > max_y) max_y = py;
            if (pz > depth) depth = pz;
        end
        res.behind_viewer = depth < 0;
        res.visible       = !res.behind_viewer
                            && (in_unit(min_x) || in_unit(max_x))
                            && (in_unit(min_y) || in_unit(max_y));
        res.rect_min_x    = min_x[31:0];
        res.rect_min_y    = min_y[31:0];
        res.rect_max_x    = max_x[31:0];
        res.rect_max_y    = max_y[31:0];
        res.max_depth     = depth[31:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Offer one box; hold it until accepted, then either keep valid high for the
    // next box of the burst or drop it for a random gap.
    task automatic send_box(in_t b);
        in_valid <= 1'b1;
        in_data  <= b;
        do
            @(posedge clk);
        while (in_stall);
        pending_rects.push_back(project_box(b));
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Drop valid, wait for every owed rectangle, then let the pipeline settle.
    task automatic drain_boxes();
        in_valid <= 1'b0;
        while (pending_rects.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write a set of registers back to back; only ever called while idle.
    task automatic load_matrix(logic [REG_W-1:0] rows [REG_NUM]);
        for (int i = 0; i < REG_NUM; i++)
        begin
            @(posedge clk);
            wr_en    <= 1'b1;
            wr_index <= mat_idx_e'(i);
            wr_data  <= rows[i];
            matrix_copy[i] = rows[i];
        end
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    function automatic logic [REG_W-1:0] pair(int lo_col, int hi_col);
        return {hi_col, lo_col};
    endfunction

    function automatic in_t make_box(int lx, int ly, int lz, int hx, int hy, int hz);
        in_t b;
        b.box_low_x  = lx;
        b.box_low_y  = ly;
        b.box_low_z  = lz;
        b.box_high_x = hx;
        b.box_high_y = hy;
        b.box_high_z = hz;
        return b;
    endfunction

    // Mostly coordinates near the view volume, some mid range, some any 32 bits.
    function automatic int pick_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return $signed($urandom_range(0, 8 * Q_ONE)) - 4 * Q_ONE;
        else if (sel < 8)
            return $signed($urandom_range(0, 2000 * Q_ONE)) - 1000 * Q_ONE;
        return $urandom;
    endfunction

    // Well-ordered boxes most of the time; swap an axis now and then.
    function automatic in_t pick_box();
        int   a;
        int   c;
        int   lo [3];
        int   hi [3];
        for (int i = 0; i < 3; i++)
        begin
            a = pick_coord();
            c = pick_coord();
            if (($signed(a) > $signed(c)) != ($urandom_range(0, 9) == 0))
            begin
                lo[i] = c;
                hi[i] = a;
            end
            else
            begin
                lo[i] = a;
                hi[i] = c;
            end
        end
        return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endfunction

    // Perspective style: x, y scaled, depth from z, w = -z plus offset.
    function automatic void perspective(output logic [REG_W-1:0] rows [REG_NUM],
                                        input int sx, input int sy, input int dz,
                                        input int dw);
        rows[R0_C01] = pair(sx, 0);
        rows[R0_C23] = pair(0, 0);
        rows[R1_C01] = pair(0, sy);
        rows[R1_C23] = pair(0, 0);
        rows[R2_C01] = pair(0, 0);
        rows[R2_C23] = pair(Q_NEG_ONE, dz);
        rows[R3_C01] = pair(0, 0);
        rows[R3_C23] = pair(Q_NEG_ONE, dw);
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        out_t exp_rect;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_rects.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result transaction %h", out_data);
            end
            else
            begin
                exp_rect = pending_rects.pop_front();
                if (out_data.visible !== exp_rect.visible
                    || out_data.behind_viewer !== exp_rect.behind_viewer
                    || out_data.rect_min_x !== exp_rect.rect_min_x
                    || out_data.rect_min_y !== exp_rect.rect_min_y
                    || out_data.rect_max_x !== exp_rect.rect_max_x
                    || out_data.rect_max_y !== exp_rect.rect_max_y
                    || out_data.max_depth !== exp_rect.max_depth)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch: exp vis %b bhd %b x %h..%h y %h..%h z %h",
                                 exp_rect.visible, exp_rect.behind_viewer,
                                 exp_rect.rect_min_x, exp_rect.rect_max_x,
                                 exp_rect.rect_min_y, exp_rect.rect_max_y,
                                 exp_rect.max_depth,
                                 "\n          got vis %b bhd %b x %h..%h y %h..%h z %h",
                                 out_data.visible, out_data.behind_viewer,
                                 out_data.rect_min_x, out_data.rect_max_x,
                                 out_data.rect_min_y, out_data.rect_max_y,
                                 out_data.max_depth);
                end
            end
        end
    end

    // Back-pressure: switch at random among calm, light, heavy and periodic stretches.
    int stall_mode;
    int stall_cycles;
    always @(posedge clk)
    begin
        if (stall_cycles == 0)
        begin
            stall_mode   <= $urandom_range(0, 3);
            stall_cycles <= $urandom_range(40, 300);
        end
        else
            stall_cycles <= stall_cycles - 1;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 9) < 3);
            2:       out_stall <= ($urandom_range(0, 9) < 8);
            default: out_stall <= (stall_cycles % 5 < 2);
        endcase
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Identity matrix out of reset: inside, outside, behind, extremes, swapped.
    task automatic test_reset_identity();
        send_box(make_box(-Q_ONE / 2, -Q_ONE / 2, 0, Q_ONE / 2, Q_ONE / 2, Q_ONE / 2));
        send_box(make_box(2 * Q_ONE, 2 * Q_ONE, 0, 3 * Q_ONE, 3 * Q_ONE, Q_ONE));
        send_box(make_box(-Q_ONE / 4, -Q_ONE / 4, -3 * Q_ONE, 0, 0, -Q_ONE));
        send_box(make_box(0, 0, 0, 0, 0, 0));
        send_box(make_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        send_box(make_box(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN));
        send_box(make_box(Q_ONE / 2, Q_ONE / 2, Q_ONE, -Q_ONE / 2, -Q_ONE / 2, 0));
        send_box(make_box(-Q_ONE, -Q_ONE, 0, Q_ONE, Q_ONE, 0));
        send_box(make_box(-Q_ONE, 0, -Q_ONE, -Q_ONE, 0, -Q_ONE));
        send_box(make_box(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                          32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555));
        drain_boxes();
    endtask

    // Extreme matrices: zero divisors, saturated entries, large quotients.
    task automatic test_matrix_extremes();
        logic [REG_W-1:0] rows [REG_NUM];
        for (int i = 0; i < REG_NUM; i++)
            rows[i] = '0;
        load_matrix(rows);
        send_box(make_box(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE));
        send_box(make_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        drain_boxes();

        // w fixed at zero, numerators of both signs and zero.
        perspective(rows, Q_ONE, Q_ONE, 0, 0);
        rows[R3_C23] = pair(0, 0);
        load_matrix(rows);
        send_box(make_box(-Q_ONE, 0, -Q_ONE, Q_ONE, 0, Q_ONE));
        send_box(make_box(Q_ONE, -Q_ONE, Q_ONE, 2 * Q_ONE, -Q_ONE, 2 * Q_ONE));
        drain_boxes();

        for (int i = 0; i < REG_NUM; i++)
            rows[i] = pair(Q_MAX, Q_MIN);
        load_matrix(rows);
        send_box(make_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        send_box(make_box(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE));
        drain_boxes();

        // Scale by two with w of one: coordinates of magnitude 16384 or more saturate.
        perspective(rows, Q_TWO, Q_TWO, 0, Q_ONE);
        rows[R2_C23] = pair(Q_TWO, 0);
        rows[R3_C23] = pair(0, Q_ONE);
        load_matrix(rows);
        send_box(make_box(-20000 * Q_ONE, -16384 * Q_ONE, -Q_ONE,
                          20000 * Q_ONE, 16383 * Q_ONE, 20000 * Q_ONE));
        send_box(make_box(Q_ONE / 3, -Q_ONE / 3, Q_ONE / 7, Q_ONE / 3, Q_ONE / 5, Q_ONE));
        drain_boxes();

        // Writes past the last register must change nothing.
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= IDX_UNUSED;
        wr_data  <= '1;
        @(posedge clk);
        wr_en    <= 1'b0;
        send_box(make_box(-Q_ONE, -Q_ONE, 0, Q_ONE, Q_ONE, Q_ONE));
        drain_boxes();
    endtask

    // Random boxes under a run of matrices, perspective projections and raw bit patterns.
    task automatic test_random_boxes();
        logic [REG_W-1:0] rows [REG_NUM];
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p % 3 == 2)
            begin
                for (int i = 0; i < REG_NUM; i++)
                    rows[i] = {$urandom, $urandom};
            end
            else
                perspective(rows, $urandom_range(Q_ONE / 4, Q_TWO),
                            $urandom_range(Q_ONE / 4, Q_TWO),
                            $signed($urandom_range(0, Q_TWO)) - Q_ONE,
                            $signed($urandom_range(0, Q_TWO)) - Q_ONE);
            load_matrix(rows);
            repeat (PHASE_BOXES) send_box(pick_box());
            drain_boxes();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n        = 1'b0;
        wr_en        = 1'b0;
        wr_index     = '0;
        wr_data      = '0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_stall    = 1'b0;
        stall_mode   = 0;
        stall_cycles = 0;
        mismatch_count = 0;
        burst_left   = 4;
        for (int i = 0; i < REG_NUM; i++)
            matrix_copy[i] = MAT_RST[i];
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_identity();
        test_matrix_extremes();
        test_random_boxes();

        if (mismatch_count == 0 && pending_rects.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #6_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

@@ bounding_box_projection_cull.f @@
rtl/bbpc_pkg.sv
rtl/bbpc_xform.sv
rtl/bbpc_div.sv
rtl/bbpc_reduce.sv
rtl/bounding_box_projection_cull.sv
sim/tb_bounding_box_projection_cull.sv
